[rtl/core/spring_mesh_relaxation_step_unit_macros.svh]
// Assertion macros for the spring mesh step unit
`ifndef SPRING_MESH_RELAXATION_STEP_UNIT_MACROS_SVH
`define SPRING_MESH_RELAXATION_STEP_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SMRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smrs assertion failed");

// next-cycle implication
`define SMRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smrs assertion failed");

`endif

[rtl/core/smrs_pkg.sv]
// Shared types and constants of the spring mesh step unit
package smrs_pkg;

  localparam int OP_W   = 3;
  localparam int GRAB_W = 21;
  localparam int IDX_W  = 13;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_TICK    = 3'd1,
    OP_GRAB    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_INTENSITY = 2'd2
  } reg_e;

  localparam logic [7:0]  WIDTH_RST     = 8'd80;
  localparam logic [6:0]  HEIGHT_RST    = 7'd60;
  localparam logic [14:0] INTENSITY_RST = 15'd13107;
  localparam logic [14:0] INTENSITY_MIN = 15'd66;
  localparam logic [14:0] INTENSITY_MAX = 15'd19661;

endpackage

[rtl/core/spring_mesh_relaxation_step_unit.sv]
// Spring mesh relaxation step unit: lattice init, tick, grab, release, read
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   in       | in_valid_i / in_ready_o    | operation_i grab_x_i grab_y_i read_index_i
//   out      | out_valid_o / out_ready_i  | result_x_o result_y_o result_index_o
//   apb      | psel penable pwrite pready | paddr pwdata prdata
//
// Init: reciprocal setup by restoring division, then one write per buffer per node.
// Tick: five serial reads of the position memory per interior node, then laplacian,
// multiply and write-back. Grab: pipelined scan of the interior nodes unless one is held.
// One item at a time; the finished result sits in an output register, so the next
// item is taken while it waits. Reset clears control only; memories hold garbage.
`include "spring_mesh_relaxation_step_unit_macros.svh"

module spring_mesh_relaxation_step_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [smrs_pkg::OP_W-1:0]     operation_i,
  input  logic [smrs_pkg::GRAB_W-1:0]   grab_x_i,
  input  logic [smrs_pkg::GRAB_W-1:0]   grab_y_i,
  input  logic [smrs_pkg::IDX_W-1:0]    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] result_x_o,
  output logic signed [COORD_WIDTH-1:0] result_y_o,
  output logic [smrs_pkg::IDX_W-1:0]    result_index_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import smrs_pkg::*;

  localparam int NODES = MAX_COLUMNS * MAX_ROWS;
  localparam int NW    = $clog2(NODES);
  localparam int AW    = $clog2(2 * NODES);
  localparam int CLW   = $clog2(MAX_COLUMNS + 1);
  localparam int RLW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = COORD_WIDTH;
  localparam int LW    = CW + 3;       // laplacian
  localparam int PW    = LW + 33;      // laplacian times gain factor
  localparam int SW    = CW + 5;       // sums before saturation
  localparam int DW    = CW + 4;       // manhattan distance
  localparam int QW    = 21;           // lattice quotient, up to 2^20

  localparam logic signed [SW-1:0] SAT_HI = {{6{1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{6{1'b1}}, {(CW-1){1'b0}}};
  localparam logic [PW-1:0]        RND_HALF = {{(PW-32){1'b0}}, 1'b1, 31'b0};

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_INIT_DIV = 18'h00002,
    S_INIT_WR  = 18'h00004,
    S_T_RC     = 18'h00008,
    S_T_RL     = 18'h00010,
    S_T_RR     = 18'h00020,
    S_T_RU     = 18'h00040,
    S_T_RD     = 18'h00080,
    S_T_LAP    = 18'h00100,
    S_T_MUL    = 18'h00200,
    S_T_WB     = 18'h00400,
    S_G_SCAN   = 18'h00800,
    S_G_DRAIN  = 18'h01000,
    S_G_PIN0   = 18'h02000,
    S_G_PIN1   = 18'h04000,
    S_RD_ISSUE = 18'h08000,
    S_RD_DATA  = 18'h10000,
    S_DONE     = 18'h20000
  } state_e;

  function automatic logic [CW-1:0] sat_f(input logic signed [SW-1:0] v);
    logic [CW-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[CW-1:0];
    else if (v < SAT_LO) r = SAT_LO[CW-1:0];
    else                 r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] maddr_f(input logic b, input logic [NW-1:0] n);
    return b ? AW'(NODES) + AW'(n) : AW'(n);
  endfunction

  // configuration
  logic [7:0]  mesh_width_q;
  logic [6:0]  mesh_height_q;
  logic [14:0] intensity_q;
  logic [CLW-1:0] eff_w;
  logic [RLW-1:0] eff_h;
  logic [14:0]    eff_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_width_q  <= WIDTH_RST;
      mesh_height_q <= HEIGHT_RST;
      intensity_q   <= INTENSITY_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:     mesh_width_q  <= pwdata[7:0];
        REG_HEIGHT:    mesh_height_q <= pwdata[6:0];
        REG_INTENSITY: intensity_q   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:     prdata = 32'(mesh_width_q);
      REG_HEIGHT:    prdata = 32'(mesh_height_q);
      REG_INTENSITY: prdata = 32'(intensity_q);
      default:       prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  always_comb begin
    if (mesh_width_q < 8'd2)                   eff_w = CLW'(2);
    else if (32'(mesh_width_q) > MAX_COLUMNS)  eff_w = CLW'(MAX_COLUMNS);
    else                                       eff_w = CLW'(mesh_width_q);
    if (mesh_height_q < 7'd2)                  eff_h = RLW'(2);
    else if (32'(mesh_height_q) > MAX_ROWS)    eff_h = RLW'(MAX_ROWS);
    else                                       eff_h = RLW'(mesh_height_q);
    if (intensity_q < INTENSITY_MIN)           eff_k = INTENSITY_MIN;
    else if (intensity_q > INTENSITY_MAX)      eff_k = INTENSITY_MAX;
    else                                       eff_k = intensity_q;
  end

  // memories
  logic [CW-1:0] posx_mem [2*NODES];
  logic [CW-1:0] posy_mem [2*NODES];
  logic [CW-1:0] velx_mem [NODES];
  logic [CW-1:0] vely_mem [NODES];
  logic [AW-1:0] pos_raddr, pos_waddr;
  logic [NW-1:0] vel_raddr, vel_waddr;
  logic          pos_we, vel_we;
  logic [CW-1:0] pos_wx, pos_wy;
  logic [CW-1:0] posx_rd_q, posy_rd_q, velx_rd_q, vely_rd_q;
  logic          velc_we;
  logic [CW-1:0] velc_wx, velc_wy;

  // init and grab write zero velocity; tick writes the computed one
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      posx_mem[pos_waddr] <= pos_wx;
      posy_mem[pos_waddr] <= pos_wy;
    end
    if (vel_we) begin
      velx_mem[vel_waddr] <= '0;
      vely_mem[vel_waddr] <= '0;
    end else if (velc_we) begin
      velx_mem[vel_waddr] <= velc_wx;
      vely_mem[vel_waddr] <= velc_wy;
    end
    posx_rd_q <= posx_mem[pos_raddr];
    posy_rd_q <= posy_mem[pos_raddr];
    velx_rd_q <= velx_mem[vel_raddr];
    vely_rd_q <= vely_mem[vel_raddr];
  end

  // control and datapath registers
  state_e state_q, state_d;
  logic [GRAB_W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              cur_buf_q, cur_buf_d;
  logic              held_valid_q, held_valid_d;
  logic [NW-1:0]     held_node_q, held_node_d;
  logic [NW-1:0]     n_q, n_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [RLW-1:0]    row_q, row_d;
  logic              phase_q, phase_d;
  logic [4:0]        dcnt_q, dcnt_d;
  logic [CLW:0]      remx_q, remx_d;
  logic [RLW:0]      remy_q, remy_d;
  logic [QW-1:0]     qstx_q, qstx_d, qsty_q, qsty_d;  // 2^20 / d
  logic [QW-1:0]     qx_q, qx_d, qy_q, qy_d;
  logic [CLW:0]      rx_q, rx_d;
  logic [RLW:0]      ry_q, ry_d;
  logic [31:0]       kk_q, kk_d, k16_q, k16_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [LW-1:0] accx_q, accx_d, accy_q, accy_d, lapx_q, lapx_d, lapy_q, lapy_d;
  logic signed [PW-1:0] prodx_q, prodx_d, prody_q, prody_d;
  logic              p1_valid_q, p1_valid_d, p1_last_q, p1_last_d;
  logic [NW-1:0]     p1_idx_q, p1_idx_d;
  logic              p2_valid_q, p2_valid_d, p2_last_q, p2_last_d;
  logic [NW-1:0]     p2_idx_q, p2_idx_d;
  logic [DW-1:0]     p2_dist_q, p2_dist_d;
  logic              found_q, found_d;
  logic [DW-1:0]     best_q, best_d;
  logic [NW-1:0]     best_n_q, best_n_d;
  logic [CW-1:0]     res_x_q, res_x_d, res_y_q, res_y_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     out_x_q, out_y_q;
  logic [IDX_W-1:0]  out_idx_q;

  // helper terms
  logic [NW-1:0]  w_n;
  logic           col_last, row_last, icol_last, irow_last, no_int;
  logic [NW:0]    wh;
  logic [CLW-1:0] dx;
  logic [RLW-1:0] dy;
  logic [CLW:0]   shx, rx_sum;
  logic [RLW:0]   shy, ry_sum;
  logic           nbit;
  logic signed [DW-1:0] dist_x, dist_y;
  logic [DW-1:0]  man_dist;
  logic           better;
  logic signed [LW-1:0] rdx_l, rdy_l;
  logic signed [PW-33:0] gainx, gainy;
  logic signed [SW-1:0]  vsx, vsy, psx, psy;
  logic [CW-1:0]  vnx, vny;
  logic [CW-1:0]  gsx, gsy;
  logic [31:0]    mx, my;

  assign w_n       = NW'(eff_w);
  assign col_last  = (col_q == eff_w - CLW'(2));
  assign row_last  = (row_q == eff_h - RLW'(2));
  assign icol_last = (col_q == eff_w - CLW'(1));
  assign irow_last = (row_q == eff_h - RLW'(1));
  assign no_int    = (eff_w == CLW'(2)) || (eff_h == RLW'(2));
  assign wh        = (NW+1)'(eff_w) * (NW+1)'(eff_h);
  assign dx        = eff_w - CLW'(1);
  assign dy        = eff_h - RLW'(1);
  assign nbit      = (dcnt_q == 5'd20);
  assign shx       = {remx_q[CLW-1:0], nbit};
  assign shy       = {remy_q[RLW-1:0], nbit};
  assign rx_sum    = rx_q + remx_q;
  assign ry_sum    = ry_q + remy_q;
  assign rdx_l     = LW'($signed(posx_rd_q));
  assign rdy_l     = LW'($signed(posy_rd_q));
  assign gsx       = sat_f($signed(SW'(gx_q)));
  assign gsy       = sat_f($signed(SW'(gy_q)));

  // distance for the grab scan, from the data read last cycle
  always_comb begin
    dist_x = $signed(DW'(gx_q)) - DW'($signed(posx_rd_q));
    dist_y = $signed(DW'(gy_q)) - DW'($signed(posy_rd_q));
    if (dist_x < 0) dist_x = -dist_x;
    if (dist_y < 0) dist_y = -dist_y;
    man_dist = DW'(dist_x) + DW'(dist_y);
    better   = !found_q || (p2_dist_q < best_q);
  end

  // gain: opposing signs use k*(1+k), else k; rounding adds one half then floors
  always_comb begin
    mx    = (lapx_q[LW-1] != vx_q[CW-1]) ? kk_q : k16_q;
    my    = (lapy_q[LW-1] != vy_q[CW-1]) ? kk_q : k16_q;
    gainx = (PW-32)'((prodx_q + $signed(RND_HALF)) >>> 32);
    gainy = (PW-32)'((prody_q + $signed(RND_HALF)) >>> 32);
    vsx   = SW'(vx_q) + SW'(gainx);
    vsy   = SW'(vy_q) + SW'(gainy);
    vnx   = sat_f(vsx);
    vny   = sat_f(vsy);
    psx   = SW'(cx_q) + SW'($signed(vnx));
    psy   = SW'(cy_q) + SW'($signed(vny));
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;   gx_d = gx_q;   gy_d = gy_q;   ridx_d = ridx_q;
    cur_buf_d = cur_buf_q;   held_valid_d = held_valid_q;   held_node_d = held_node_q;
    n_d = n_q;   col_d = col_q;   row_d = row_q;   phase_d = phase_q;   dcnt_d = dcnt_q;
    remx_d = remx_q;   remy_d = remy_q;   qstx_d = qstx_q;   qsty_d = qsty_q;
    qx_d = qx_q;   qy_d = qy_q;   rx_d = rx_q;   ry_d = ry_q;
    kk_d = kk_q;   k16_d = k16_q;
    cx_d = cx_q;   cy_d = cy_q;   vx_d = vx_q;   vy_d = vy_q;
    accx_d = accx_q;   accy_d = accy_q;   lapx_d = lapx_q;   lapy_d = lapy_q;
    prodx_d = prodx_q;   prody_d = prody_q;
    p1_valid_d = 1'b0;   p1_last_d = p1_last_q;   p1_idx_d = p1_idx_q;
    p2_valid_d = p1_valid_q;   p2_last_d = p1_last_q;   p2_idx_d = p1_idx_q;
    p2_dist_d = man_dist;
    found_d = found_q;   best_d = best_q;   best_n_d = best_n_q;
    res_x_d = res_x_q;   res_y_d = res_y_q;   res_idx_d = res_idx_q;
    pos_we = 1'b0;   vel_we = 1'b0;   velc_we = 1'b0;
    pos_raddr = '0;   vel_raddr = n_q;   pos_waddr = '0;   vel_waddr = n_q;
    pos_wx = '0;   pos_wy = '0;   velc_wx = vnx;   velc_wy = vny;

    // grab scan: keep the first node on ties
    if (p2_valid_q && better) begin
      found_d  = 1'b1;
      best_d   = p2_dist_q;
      best_n_d = p2_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          gx_d = grab_x_i;   gy_d = grab_y_i;   ridx_d = read_index_i;
          res_x_d = '0;   res_y_d = '0;   res_idx_d = '0;
          n_d   = w_n + NW'(1);
          col_d = CLW'(1);
          row_d = RLW'(1);
          unique case (operation_i)
            OP_INIT: begin
              dcnt_d = 5'd20;   remx_d = '0;   remy_d = '0;
              qstx_d = '0;   qsty_d = '0;
              state_d = S_INIT_DIV;
            end
            OP_TICK: begin
              kk_d  = 32'(32'(eff_k) * (32'd65536 + 32'(eff_k)));
              k16_d = {1'b0, eff_k, 16'b0};
              if (no_int) begin
                cur_buf_d = !cur_buf_q;
                state_d   = S_DONE;
              end else begin
                state_d = S_T_RC;
              end
            end
            OP_GRAB: begin
              found_d = 1'b0;
              if (held_valid_q)  state_d = S_G_PIN0;
              else if (no_int)   state_d = S_DONE;
              else               state_d = S_G_SCAN;
            end
            OP_RELEASE: begin
              held_valid_d = 1'b0;
              state_d      = S_DONE;
            end
            OP_READ: begin
              res_idx_d = read_index_i;
              if (32'(read_index_i) < 32'(wh)) state_d = S_RD_ISSUE;
              else                             state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // restoring division of 2^20 by (w-1) and (h-1), one bit a cycle
      S_INIT_DIV: begin
        if (shx >= (CLW+1)'(dx)) begin
          remx_d = shx - (CLW+1)'(dx);
          qstx_d = {qstx_q[QW-2:0], 1'b1};
        end else begin
          remx_d = shx;
          qstx_d = {qstx_q[QW-2:0], 1'b0};
        end
        if (shy >= (RLW+1)'(dy)) begin
          remy_d = shy - (RLW+1)'(dy);
          qsty_d = {qsty_q[QW-2:0], 1'b1};
        end else begin
          remy_d = shy;
          qsty_d = {qsty_q[QW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == 5'd0) begin
          qx_d = '0;   rx_d = (CLW+1)'(dx >> 1);
          qy_d = '0;   ry_d = (RLW+1)'(dy >> 1);
          n_d = '0;   col_d = '0;   row_d = '0;   phase_d = 1'b0;
          state_d = S_INIT_WR;
        end
      end

      S_INIT_WR: begin
        pos_we    = 1'b1;
        pos_waddr = maddr_f(phase_q, n_q);
        pos_wx    = CW'(qx_q);
        pos_wy    = CW'(qy_q);
        vel_we    = !phase_q;
        phase_d   = !phase_q;
        if (phase_q) begin
          n_d = n_q + NW'(1);
          if (icol_last) begin
            col_d = '0;
            qx_d  = '0;
            rx_d  = (CLW+1)'(dx >> 1);
            row_d = row_q + RLW'(1);
            if (ry_sum >= (RLW+1)'(dy)) begin
              ry_d = ry_sum - (RLW+1)'(dy);
              qy_d = qy_q + qsty_q + QW'(1);
            end else begin
              ry_d = ry_sum;
              qy_d = qy_q + qsty_q;
            end
            if (irow_last) state_d = S_DONE;
          end else begin
            col_d = col_q + CLW'(1);
            if (rx_sum >= (CLW+1)'(dx)) begin
              rx_d = rx_sum - (CLW+1)'(dx);
              qx_d = qx_q + qstx_q + QW'(1);
            end else begin
              rx_d = rx_sum;
              qx_d = qx_q + qstx_q;
            end
          end
        end
      end

      S_T_RC: begin
        pos_raddr = maddr_f(cur_buf_q, n_q);
        state_d   = S_T_RL;
      end
      S_T_RL: begin
        pos_raddr = maddr_f(cur_buf_q, n_q - NW'(1));
        cx_d = $signed(posx_rd_q);   cy_d = $signed(posy_rd_q);
        vx_d = $signed(velx_rd_q);   vy_d = $signed(vely_rd_q);
        state_d = S_T_RR;
      end
      S_T_RR: begin
        pos_raddr = maddr_f(cur_buf_q, n_q + NW'(1));
        accx_d = rdx_l;   accy_d = rdy_l;
        state_d = S_T_RU;
      end
      S_T_RU: begin
        pos_raddr = maddr_f(cur_buf_q, n_q - w_n);
        accx_d = accx_q + rdx_l;   accy_d = accy_q + rdy_l;
        state_d = S_T_RD;
      end
      S_T_RD: begin
        pos_raddr = maddr_f(cur_buf_q, n_q + w_n);
        accx_d = accx_q + rdx_l;   accy_d = accy_q + rdy_l;
        state_d = S_T_LAP;
      end
      S_T_LAP: begin
        lapx_d = accx_q + rdx_l - (LW'(cx_q) <<< 2);
        lapy_d = accy_q + rdy_l - (LW'(cy_q) <<< 2);
        state_d = S_T_MUL;
      end
      S_T_MUL: begin
        prodx_d = PW'(lapx_q * $signed({1'b0, mx}));
        prody_d = PW'(lapy_q * $signed({1'b0, my}));
        state_d = S_T_WB;
      end
      S_T_WB: begin
        velc_we   = 1'b1;
        pos_we    = 1'b1;
        pos_waddr = maddr_f(!cur_buf_q, n_q);
        pos_wx    = sat_f(psx);
        pos_wy    = sat_f(psy);
        state_d   = S_T_RC;
        if (col_last) begin
          col_d = CLW'(1);
          row_d = row_q + RLW'(1);
          n_d   = n_q + NW'(3);
          if (row_last) begin
            cur_buf_d = !cur_buf_q;
            state_d   = S_DONE;
          end
        end else begin
          col_d = col_q + CLW'(1);
          n_d   = n_q + NW'(1);
        end
      end

      S_G_SCAN: begin
        pos_raddr  = maddr_f(cur_buf_q, n_q);
        p1_valid_d = 1'b1;
        p1_idx_d   = n_q;
        p1_last_d  = col_last && row_last;
        if (col_last) begin
          col_d = CLW'(1);
          row_d = row_q + RLW'(1);
          n_d   = n_q + NW'(3);
          if (row_last) state_d = S_G_DRAIN;
        end else begin
          col_d = col_q + CLW'(1);
          n_d   = n_q + NW'(1);
        end
      end
      S_G_DRAIN: begin
        if (p2_valid_q && p2_last_q) begin
          held_valid_d = 1'b1;
          held_node_d  = better ? p2_idx_q : best_n_q;
          state_d      = S_G_PIN0;
        end
      end
      S_G_PIN0: begin
        pos_we    = 1'b1;
        pos_waddr = maddr_f(1'b0, held_node_q);
        pos_wx    = gsx;
        pos_wy    = gsy;
        vel_we    = 1'b1;
        vel_waddr = held_node_q;
        state_d   = S_G_PIN1;
      end
      S_G_PIN1: begin
        pos_we    = 1'b1;
        pos_waddr = maddr_f(1'b1, held_node_q);
        pos_wx    = gsx;
        pos_wy    = gsy;
        res_x_d   = gsx;
        res_y_d   = gsy;
        res_idx_d = IDX_W'(held_node_q);
        state_d   = S_DONE;
      end

      S_RD_ISSUE: begin
        pos_raddr = maddr_f(cur_buf_q, NW'(ridx_q));
        state_d   = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_x_d = posx_rd_q;
        res_y_d = posy_rd_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_buf_q    <= 1'b0;
      held_valid_q <= 1'b0;
      held_node_q  <= '0;
      out_valid_q  <= 1'b0;
      p1_valid_q   <= 1'b0;
      p2_valid_q   <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_buf_q    <= cur_buf_d;
      held_valid_q <= held_valid_d;
      held_node_q  <= held_node_d;
      out_valid_q  <= out_valid_d;
      p1_valid_q   <= p1_valid_d;
      p2_valid_q   <= p2_valid_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx_d;   gy_q <= gy_d;   ridx_q <= ridx_d;
    n_q <= n_d;   col_q <= col_d;   row_q <= row_d;   phase_q <= phase_d;   dcnt_q <= dcnt_d;
    remx_q <= remx_d;   remy_q <= remy_d;   qstx_q <= qstx_d;   qsty_q <= qsty_d;
    qx_q <= qx_d;   qy_q <= qy_d;   rx_q <= rx_d;   ry_q <= ry_d;
    kk_q <= kk_d;   k16_q <= k16_d;
    cx_q <= cx_d;   cy_q <= cy_d;   vx_q <= vx_d;   vy_q <= vy_d;
    accx_q <= accx_d;   accy_q <= accy_d;   lapx_q <= lapx_d;   lapy_q <= lapy_d;
    prodx_q <= prodx_d;   prody_q <= prody_d;
    p1_last_q <= p1_last_d;   p1_idx_q <= p1_idx_d;
    p2_last_q <= p2_last_d;   p2_idx_q <= p2_idx_d;   p2_dist_q <= p2_dist_d;
    best_q <= best_d;   best_n_q <= best_n_d;
    res_x_q <= res_x_d;   res_y_q <= res_y_d;   res_idx_q <= res_idx_d;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
      out_idx_q <= res_idx_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_x_o     = $signed(out_x_q);
  assign result_y_o     = $signed(out_y_q);
  assign result_index_o = out_idx_q;

  `SMRS_ASSERT_IMP(a_tick_other_bank, (state_q == S_T_WB), ((pos_waddr >= AW'(NODES)) != cur_buf_q))
  `SMRS_ASSERT_IMP(a_hold_from_scan, (held_valid_d && !held_valid_q), (state_q == S_G_DRAIN))
  `SMRS_ASSERT_NXT(a_accept_busy, (in_valid_i && in_ready_o), !in_ready_o)
  `SMRS_ASSERT_IMP(a_pos_write_src, pos_we, ((state_q == S_INIT_WR) || (state_q == S_T_WB) || (state_q == S_G_PIN0) || (state_q == S_G_PIN1)))

endmodule

[tb/tb_spring_mesh_relaxation_step_unit.sv]
// Testbench for the spring mesh step unit: directed table, random phases, model-based checks
`timescale 1ns / 100ps

module tb_spring_mesh_relaxation_step_unit;
  import smrs_pkg::*;

  localparam int NODES = 8192;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int ONE_Q20 = 1048576;
  localparam longint COORD_HI = 64'sd8388607;
  localparam longint COORD_LO = -64'sd8388608;

  typedef struct {
    logic [2:0]  op;
    logic [20:0] gx;
    logic [20:0] gy;
    logic [12:0] ri;
    bit          typed;
    int          ex;
    int          ey;
    int          ei;
  } stim_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [12:0]        idx;
  } node_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [2:0] operation_i;
  logic [20:0] grab_x_i, grab_y_i;
  logic [12:0] read_index_i;
  logic out_valid_o, out_ready_i;
  logic signed [23:0] result_x_o, result_y_o;
  logic [12:0] result_index_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  spring_mesh_relaxation_step_unit uut (.*);

  // predictor state
  int pos_x [0:1][0:NODES-1];
  int pos_y [0:1][0:NODES-1];
  int vel_x [0:NODES-1];
  int vel_y [0:NODES-1];
  bit cur_buf, held_valid;
  int held_node;
  logic [7:0] cfg_width;
  logic [6:0] cfg_height;
  logic [14:0] cfg_intensity;

  node_res_t pending_positions[$];
  int errors = 0;
  int burst_left = 0;
  int ready_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver back-pressure, mode changes now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    node_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_positions.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d idx=%0d", $time,
                 result_x_o, result_y_o, result_index_o);
        errors++;
      end else begin
        e = pending_positions.pop_front();
        if (result_x_o !== e.x) begin
          $display("%0t: result_x expected %0d actual %0d", $time, e.x, result_x_o);
          errors++;
        end
        if (result_y_o !== e.y) begin
          $display("%0t: result_y expected %0d actual %0d", $time, e.y, result_y_o);
          errors++;
        end
        if (result_index_o !== e.idx) begin
          $display("%0t: result_index expected %0d actual %0d", $time, e.idx,
                   result_index_o);
          errors++;
        end
      end
    end
  end

  function automatic int eff_w();
    return (cfg_width < 2) ? 2 : (cfg_width > 128) ? 128 : int'(cfg_width);
  endfunction

  function automatic int eff_h();
    return (cfg_height < 2) ? 2 : (cfg_height > 64) ? 64 : int'(cfg_height);
  endfunction

  function automatic longint eff_k();
    if (cfg_intensity < INTENSITY_MIN) return longint'(INTENSITY_MIN);
    if (cfg_intensity > INTENSITY_MAX) return longint'(INTENSITY_MAX);
    return longint'(cfg_intensity);
  endfunction

  function automatic int sat_coord(longint v);
    if (v > COORD_HI) return int'(COORD_HI);
    if (v < COORD_LO) return int'(COORD_LO);
    return int'(v);
  endfunction

  // nearest, ties toward +inf
  function automatic longint round_shift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint spring_gain(longint lap, int vel, longint k);
    if ((lap < 0) != (vel < 0)) return round_shift(lap * (65536 + k) * k, 32);
    return round_shift(lap * k, 16);
  endfunction

  function automatic int lattice_coord(int k, int n);
    longint d;
    d = n - 1;
    return int'(((longint'(k) <<< 20) + d / 2) / d);
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic node_res_t mesh_apply(stim_t s);
    node_res_t r;
    int w, h, cb, nb, n, best_node, v, vx, vy;
    longint k, lx, ly, gx, gy, d, best;
    bit found;
    w = eff_w();
    h = eff_h();
    cb = int'(cur_buf);
    nb = int'(!cur_buf);
    r = '{x: '0, y: '0, idx: '0};
    case (s.op)
      OP_INIT: begin
        for (int i = 0; i < h; i++)
          for (int j = 0; j < w; j++) begin
            n = i * w + j;
            pos_x[0][n] = lattice_coord(j, w);
            pos_x[1][n] = pos_x[0][n];
            pos_y[0][n] = lattice_coord(i, h);
            pos_y[1][n] = pos_y[0][n];
            vel_x[n] = 0;
            vel_y[n] = 0;
          end
      end
      OP_TICK: begin
        k = eff_k();
        for (int i = 1; i + 1 < h; i++)
          for (int j = 1; j + 1 < w; j++) begin
            n = i * w + j;
            lx = longint'(pos_x[cb][n-1]) + pos_x[cb][n+1] + pos_x[cb][n-w]
               + pos_x[cb][n+w] - 4 * longint'(pos_x[cb][n]);
            ly = longint'(pos_y[cb][n-1]) + pos_y[cb][n+1] + pos_y[cb][n-w]
               + pos_y[cb][n+w] - 4 * longint'(pos_y[cb][n]);
            vx = sat_coord(longint'(vel_x[n]) + spring_gain(lx, vel_x[n], k));
            vy = sat_coord(longint'(vel_y[n]) + spring_gain(ly, vel_y[n], k));
            vel_x[n] = vx;
            vel_y[n] = vy;
            pos_x[nb][n] = sat_coord(longint'(pos_x[cb][n]) + vx);
            pos_y[nb][n] = sat_coord(longint'(pos_y[cb][n]) + vy);
          end
        cur_buf = !cur_buf;
      end
      OP_GRAB: begin
        gx = longint'(s.gx);
        gy = longint'(s.gy);
        if (!held_valid) begin
          found = 0;
          best = 0;
          best_node = 0;
          for (int i = 1; i + 1 < h; i++)
            for (int j = 1; j + 1 < w; j++) begin
              v = i * w + j;
              d = absl(gx - pos_x[cb][v]) + absl(gy - pos_y[cb][v]);
              if (!found || d < best) begin
                found = 1;
                best = d;
                best_node = v;
              end
            end
          if (!found) return r;
          held_valid = 1;
          held_node = best_node;
        end
        v = held_node % NODES;
        pos_x[0][v] = sat_coord(gx);
        pos_x[1][v] = pos_x[0][v];
        pos_y[0][v] = sat_coord(gy);
        pos_y[1][v] = pos_y[0][v];
        vel_x[v] = 0;
        vel_y[v] = 0;
        r = '{x: 24'(pos_x[0][v]), y: 24'(pos_y[0][v]), idx: 13'(v)};
      end
      OP_RELEASE: held_valid = 0;
      OP_READ: begin
        if (int'(s.ri) < w * h)
          r = '{x: 24'(pos_x[cb][s.ri]), y: 24'(pos_y[cb][s.ri]), idx: s.ri};
        else r.idx = s.ri;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic reg_write(input reg_e r, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_WIDTH: cfg_width = value[7:0];
      REG_HEIGHT: cfg_height = value[6:0];
      default: cfg_intensity = value[14:0];
    endcase
  endtask

  task automatic send_item(input stim_t s);
    node_res_t r;
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= s.op;
    grab_x_i <= s.gx;
    grab_y_i <= s.gy;
    read_index_i <= s.ri;
    @(posedge clk_i iff in_ready_o);
    r = mesh_apply(s);
    if (s.typed) r = '{x: 24'(s.ex), y: 24'(s.ey), idx: 13'(s.ei)};
    pending_positions.push_back(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 8);
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    wait (pending_positions.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic stim_t mk(logic [2:0] op, int gx = 0, int gy = 0, int ri = 0);
    return '{op: op, gx: 21'(gx), gy: 21'(gy), ri: 13'(ri), typed: 0, ex: 0, ey: 0, ei: 0};
  endfunction

  function automatic stim_t mk_typed(logic [2:0] op, int ri, int ex, int ey, int ei);
    return '{op: op, gx: '0, gy: '0, ri: 13'(ri), typed: 1, ex: ex, ey: ey, ei: ei};
  endfunction

  function automatic stim_t random_item();
    int sel, area;
    stim_t s;
    area = eff_w() * eff_h();
    sel = $urandom_range(0, 99);
    s = mk(OP_READ);
    s.gx = 21'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2097151)
                                           : $urandom_range(0, ONE_Q20));
    s.gy = 21'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2097151)
                                           : $urandom_range(0, ONE_Q20));
    s.ri = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                           : $urandom_range(0, area - 1));
    if (sel < 30) s.op = OP_TICK;
    else if (sel < 55) s.op = OP_GRAB;
    else if (sel < 65) s.op = OP_RELEASE;
    else if (sel < 90) s.op = OP_READ;
    else if (sel < 93) s.op = OP_INIT;
    else s.op = 3'($urandom_range(5, 7));
    return s;
  endfunction

  initial begin
    stim_t dir_rows[$];
    int done_items, n_items, sel;
    logic [31:0] w_val, h_val, i_val;
    in_valid_i <= 1'b0;
    operation_i <= '0;
    grab_x_i <= '0;
    grab_y_i <= '0;
    read_index_i <= '0;
    out_ready_i <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_intensity = INTENSITY_RST;
    cur_buf = 0;
    held_valid = 0;
    held_node = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset geometry (80 x 60)
    dir_rows = '{
      mk_typed(OP_INIT, 0, 0, 0, 0),
      mk_typed(OP_READ, 0, 0, 0, 0),
      mk_typed(OP_READ, 4799, ONE_Q20, ONE_Q20, 4799),
      mk_typed(OP_READ, 79, ONE_Q20, 0, 79),
      mk_typed(OP_READ, 4720, 0, ONE_Q20, 4720),
      mk_typed(OP_READ, 8191, 0, 0, 8191),
      mk_typed(OP_RSVD5, 0, 0, 0, 0),
      mk_typed(OP_RSVD6, 0, 0, 0, 0),
      mk_typed(OP_RSVD7, 0, 0, 0, 0),
      mk_typed(OP_RELEASE, 0, 0, 0, 0),
      mk(OP_GRAB, 0, 0),
      mk(OP_TICK),
      mk(OP_READ, 0, 0, 81),
      mk(OP_GRAB, 2097151, 2097151),
      mk(OP_TICK),
      mk(OP_READ, 0, 0, 81),
      mk(OP_READ, 0, 0, 82),
      mk_typed(OP_RELEASE, 0, 0, 0, 0),
      mk(OP_GRAB, ONE_Q20, ONE_Q20),
      mk(OP_TICK),
      mk_typed(OP_INIT, 0, 0, 0, 0),
      mk_typed(OP_READ, 4799, ONE_Q20, ONE_Q20, 4799),
      mk_typed(OP_RELEASE, 0, 0, 0, 0)
    };
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random phases, mostly small meshes
    done_items = 0;
    while (done_items < 70) begin
      in_valid_i <= 1'b0;
      wait_idle();
      sel = $urandom_range(0, 9);
      w_val = $urandom_range(2, 12);
      h_val = $urandom_range(2, 10);
      if (sel == 0) begin
        w_val = $urandom_range(0, 1);
        h_val = $urandom_range(0, 5);
      end else if (sel == 1) begin
        w_val = ($urandom_range(0, 1) == 0) ? 32'd128 : $urandom_range(129, 255);
        h_val = $urandom_range(2, 4);
      end else if (sel == 2) begin
        w_val = $urandom_range(2, 6);
        h_val = ($urandom_range(0, 1) == 0) ? 32'd64 : $urandom_range(65, 127);
      end
      case ($urandom_range(0, 4))
        0: i_val = 32'd0;
        1: i_val = 32'h7FFF;
        2: i_val = 32'(INTENSITY_MIN);
        3: i_val = 32'(INTENSITY_MAX);
        default: i_val = $urandom_range(0, 32767);
      endcase
      reg_write(REG_WIDTH, w_val);
      reg_write(REG_HEIGHT, h_val);
      reg_write(REG_INTENSITY, i_val);
      send_item(mk(OP_INIT));
      n_items = $urandom_range(8, 20);
      repeat (n_items) begin
        send_item(random_item());
        done_items++;
      end
    end

    // largest mesh, a few items only
    in_valid_i <= 1'b0;
    wait_idle();
    reg_write(REG_WIDTH, 32'd255);
    reg_write(REG_HEIGHT, 32'd127);
    reg_write(REG_INTENSITY, 32'h7FFF);
    send_item(mk(OP_INIT));
    send_item(mk(OP_RELEASE));
    send_item(mk(OP_GRAB, 524288, 262144));
    send_item(mk(OP_TICK));
    send_item(mk(OP_READ, 0, 0, 8191));
    send_item(mk(OP_READ, 0, 0, $urandom_range(0, 8191)));

    in_valid_i <= 1'b0;
    wait (pending_positions.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smrs_pkg.sv
rtl/core/spring_mesh_relaxation_step_unit.sv
tb/tb_spring_mesh_relaxation_step_unit.sv
